FILE: rtl/uds_pkg.sv
// Package for the UTF-8 script language detector: codes, flags and range constants.
package uds_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned LangWidth = 3;
  localparam int unsigned NumScript = 5;

  // Bit positions of the script seen flags.
  localparam int unsigned SeenHan      = 0;
  localparam int unsigned SeenKana     = 1;
  localparam int unsigned SeenHangul   = 2;
  localparam int unsigned SeenCyrillic = 3;
  localparam int unsigned SeenLatin    = 4;

  typedef logic [NumScript-1:0] script_seen_t;
  typedef logic [CpWidth-1:0]   code_point_t;

  typedef enum logic [LangWidth-1:0] {
    LANG_NONE     = 3'd0,
    LANG_JAPANESE = 3'd1,
    LANG_CHINESE  = 3'd2,
    LANG_KOREAN   = 3'd3,
    LANG_RUSSIAN  = 3'd4,
    LANG_ENGLISH  = 3'd5
  } lang_code_e;

  // Script ranges, inclusive.
  localparam code_point_t HanLo0      = 21'h004E00;
  localparam code_point_t HanHi0      = 21'h009FFF;
  localparam code_point_t HanLo1      = 21'h003400;
  localparam code_point_t HanHi1      = 21'h004DBF;
  localparam code_point_t KanaLo0     = 21'h003040;
  localparam code_point_t KanaHi0     = 21'h0030FF;
  localparam code_point_t KanaLo1     = 21'h0031F0;
  localparam code_point_t KanaHi1     = 21'h0031FF;
  localparam code_point_t KanaLo2     = 21'h00FF66;
  localparam code_point_t KanaHi2     = 21'h00FF9F;
  localparam code_point_t HangulLo0   = 21'h00AC00;
  localparam code_point_t HangulHi0   = 21'h00D7AF;
  localparam code_point_t HangulLo1   = 21'h001100;
  localparam code_point_t HangulHi1   = 21'h0011FF;
  localparam code_point_t CyrillicLo  = 21'h000400;
  localparam code_point_t CyrillicHi  = 21'h0004FF;
  localparam code_point_t UpperLo     = 21'h000041;
  localparam code_point_t UpperHi     = 21'h00005A;
  localparam code_point_t LowerLo     = 21'h000061;
  localparam code_point_t LowerHi     = 21'h00007A;
  localparam code_point_t LatinExtLo  = 21'h0000C0;
  localparam code_point_t LatinExtHi  = 21'h00024F;

endpackage

FILE: rtl/uds_classify.sv
// Script classifier: maps one decoded code point to a script flag set with at most one bit set.
module uds_classify
  import uds_pkg::*;
(
  input  code_point_t  code_point_i,
  input  logic         cp_valid_i,
  output script_seen_t script_flag_o
);

  function automatic logic in_rng(code_point_t v, code_point_t lo, code_point_t hi);
    return (v >= lo) && (v <= hi);
  endfunction

  logic is_han, is_kana, is_hangul, is_cyr, is_latin;

  // The ranges are disjoint, so at most one flag is set.
  always_comb begin
    is_han    = in_rng(code_point_i, HanLo0, HanHi0) || in_rng(code_point_i, HanLo1, HanHi1);
    is_kana   = in_rng(code_point_i, KanaLo0, KanaHi0) || in_rng(code_point_i, KanaLo1, KanaHi1)
             || in_rng(code_point_i, KanaLo2, KanaHi2);
    is_hangul = in_rng(code_point_i, HangulLo0, HangulHi0)
             || in_rng(code_point_i, HangulLo1, HangulHi1);
    is_cyr    = in_rng(code_point_i, CyrillicLo, CyrillicHi);
    is_latin  = in_rng(code_point_i, UpperLo, UpperHi) || in_rng(code_point_i, LowerLo, LowerHi)
             || in_rng(code_point_i, LatinExtLo, LatinExtHi);

    script_flag_o               = '0;
    script_flag_o[SeenHan]      = cp_valid_i && is_han;
    script_flag_o[SeenKana]     = cp_valid_i && is_kana;
    script_flag_o[SeenHangul]   = cp_valid_i && is_hangul;
    script_flag_o[SeenCyrillic] = cp_valid_i && is_cyr;
    script_flag_o[SeenLatin]    = cp_valid_i && is_latin;
  end

endmodule

FILE: rtl/utf8_script_language_detector.sv
// Top level of the UTF-8 script language detector: decoder state, flags and result register.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o   | text_byte_i[7:0], last_byte_i
//  out     | output    | out_valid_o / out_ready_i | language_code_o[2:0]
//
// One byte word is taken per cycle unless the input is stalled. The decoder state
// (code point accumulator, remaining byte count, bad flag and script flags) updates in the
// same cycle a word is accepted, so the state loop sets the rate of one word per clock.
// A word marked last loads the language code into the output register, which shows it
// from the next cycle on, and returns the decoder state to its reset values.
// The input is stalled only while a result waits in the output register and is not
// being taken in the same cycle. Reset clears all decoder state and the output valid.
module utf8_script_language_detector
  import uds_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ByteWidth-1:0] text_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LangWidth-1:0] language_code_o
);

  code_point_t  accum_q, accum_d;
  logic [1:0]   remain_q, remain_d;
  logic         bad_q, bad_d;
  script_seen_t seen_q, seen_d;
  logic         out_valid_q, out_valid_d;
  lang_code_e   lang_q, lang_d;

  logic         accept;
  logic         is_cont;
  code_point_t  cp;
  logic         cp_valid;
  script_seen_t flag;
  script_seen_t seen_all;

  // The output register frees up in the same cycle its word is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_cont    = (text_byte_i[7:6] == 2'b10);

  // Decoder next state. Inside an open sequence every byte is consumed; outside,
  // lead bytes open a sequence, ASCII is classified directly and others are skipped.
  always_comb begin
    accum_d  = accum_q;
    remain_d = remain_q;
    bad_d    = bad_q;
    cp       = accum_q;
    cp_valid = 1'b0;
    if (remain_q != 2'd0) begin
      if (is_cont) begin
        accum_d = {accum_q[CpWidth-7:0], text_byte_i[5:0]};
      end else begin
        bad_d = 1'b1;
      end
      remain_d = remain_q - 2'd1;
      cp       = accum_d;
      cp_valid = (remain_d == 2'd0) && !bad_d;
    end else if (!text_byte_i[7]) begin
      cp       = {{(CpWidth-ByteWidth){1'b0}}, text_byte_i};
      cp_valid = 1'b1;
    end else if (text_byte_i[7:5] == 3'b110) begin
      accum_d  = {{(CpWidth-5){1'b0}}, text_byte_i[4:0]};
      remain_d = 2'd1;
      bad_d    = 1'b0;
    end else if (text_byte_i[7:4] == 4'b1110) begin
      accum_d  = {{(CpWidth-4){1'b0}}, text_byte_i[3:0]};
      remain_d = 2'd2;
      bad_d    = 1'b0;
    end else if (text_byte_i[7:3] == 5'b11110) begin
      accum_d  = {{(CpWidth-3){1'b0}}, text_byte_i[2:0]};
      remain_d = 2'd3;
      bad_d    = 1'b0;
    end
  end

  uds_classify u_classify (
    .code_point_i  (cp),
    .cp_valid_i    (cp_valid),
    .script_flag_o (flag)
  );

  assign seen_all = seen_q | flag;

  // Priority: Kana, Han, Hangul, Cyrillic, Latin.
  always_comb begin
    if (seen_all[SeenKana]) begin
      lang_d = LANG_JAPANESE;
    end else if (seen_all[SeenHan]) begin
      lang_d = LANG_CHINESE;
    end else if (seen_all[SeenHangul]) begin
      lang_d = LANG_KOREAN;
    end else if (seen_all[SeenCyrillic]) begin
      lang_d = LANG_RUSSIAN;
    end else if (seen_all[SeenLatin]) begin
      lang_d = LANG_ENGLISH;
    end else begin
      lang_d = LANG_NONE;
    end
  end

  assign seen_d      = seen_all;
  assign out_valid_d = (accept && last_byte_i) || (out_valid_q && !out_ready_i);

  // Decoder state: a last word returns everything to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q  <= '0;
      remain_q <= '0;
      bad_q    <= 1'b0;
      seen_q   <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        accum_q  <= '0;
        remain_q <= '0;
        bad_q    <= 1'b0;
        seen_q   <= '0;
      end else begin
        accum_q  <= accum_d;
        remain_q <= remain_d;
        bad_q    <= bad_d;
        seen_q   <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      lang_q <= lang_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign language_code_o = lang_q;

  // A last word always yields a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_byte_i |=> out_valid_o)
    else $error("last word did not produce a result");

  // After a last word the decoder starts from a clean state.
  a_last_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_byte_i |=> (remain_q == 2'd0) && (seen_q == '0) && !bad_q)
    else $error("decoder state not cleared after last word");

  // A non-last word never creates a result on an empty output.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(accept && last_byte_i) |=> !out_valid_o)
    else $error("result appeared without a last word");

  // The classifier never reports more than one script for a code point.
  a_flag_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(flag))
    else $error("code point classified into several scripts");

endmodule
